FILE: design/tag_code_learn_and_match_defines.svh
// Assertion macros for the tag code learn-and-match block.
// Used by the checker only; no other dependencies.
`ifndef TAG_CODE_LEARN_AND_MATCH_DEFINES_SVH
`define TAG_CODE_LEARN_AND_MATCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tclm_pkg.sv
// Shared types, constants and the control-byte mapping for the tag code block.
// No dependencies.
`timescale 1ns / 1ps

package tclm_pkg;

  localparam int FRAME_LEN = 16;
  localparam int CODE_LEN  = 10;

  // Code positions that can fall inside a frame.
  localparam int CODE_EFF = (CODE_LEN < FRAME_LEN) ? CODE_LEN : FRAME_LEN - 1;
  localparam int POS_W    = $clog2(FRAME_LEN);
  localparam int IDX_W    = (CODE_EFF > 1) ? $clog2(CODE_EFF) : 1;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    OUT_LEARNED = 2'd0,
    OUT_OPEN    = 2'd1,
    OUT_LOCKED  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic     done;
    outcome_t outcome;
  } match_res_t;

  function automatic logic [7:0] map_control(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_STX:  r = 8'h24; // '$'
      CH_CR:   r = 8'h28; // '('
      CH_LF:   r = 8'h29; // ')'
      CH_ETX:  r = 8'h2A; // '*'
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

FILE: design/tclm_in_reg.sv
// Input register: takes a byte, maps control characters, holds it for the core.
// Depends on tclm_pkg.
`timescale 1ns / 1ps

module tclm_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);
  import tclm_pkg::*;

  assign rx_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      held_byte <= map_control(rx_byte);
    end
  end

endmodule

FILE: design/tclm_match.sv
// Frame position counter, learned-code store and compare logic.
// Depends on tclm_pkg.
`timescale 1ns / 1ps

module tclm_match (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data,
  output tclm_pkg::match_res_t res
);
  import tclm_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             learning;
  logic             mismatch_seen;
  logic             mismatch_seen_next;
  logic [7:0]       stored_code [CODE_EFF];

  logic             in_code;
  logic             last;
  logic [IDX_W-1:0] idx;
  logic             byte_differs;

  assign in_code = (pos >= POS_W'(1)) && (pos <= POS_W'(CODE_EFF));
  assign last    = (pos == POS_W'(FRAME_LEN - 1));
  assign idx     = IDX_W'(pos - POS_W'(1));

  assign byte_differs = in_code && !learning && (stored_code[idx] != data);

  always_comb begin
    res.done = last;
    if (learning) begin
      res.outcome = OUT_LEARNED;
    end else if (mismatch_seen || byte_differs) begin
      res.outcome = OUT_LOCKED;
    end else begin
      res.outcome = OUT_OPEN;
    end
  end

  assign pos_next           = last ? '0 : pos + POS_W'(1);
  assign mismatch_seen_next = last ? 1'b0 : (mismatch_seen || byte_differs);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      learning      <= 1'b1;
      mismatch_seen <= 1'b0;
    end else if (step) begin
      pos           <= pos_next;
      mismatch_seen <= mismatch_seen_next;
      if (last) begin
        learning <= 1'b0;
      end
    end
  end

  // Code store, written only during the learn frame.
  always_ff @(posedge clk) begin
    if (step && learning && in_code) begin
      stored_code[idx] <= data;
    end
  end

endmodule

FILE: design/tclm_out_reg.sv
// Result register holding one frame outcome until it is taken.
// Depends on tclm_pkg.
`timescale 1ns / 1ps

module tclm_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  tclm_pkg::match_res_t res,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [1:0]           outcome
);
  import tclm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load && res.done) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.done) begin
      outcome <= res.outcome;
    end
  end

endmodule

FILE: design/tag_code_learn_and_match.sv
// Top level of the tag code learn-and-match block.
// Depends on tclm_pkg, tclm_in_reg, tclm_match and tclm_out_reg.
//
//   channel | signals                       | moves
//   --------+-------------------------------+-------------------------------
//   rx      | rx_valid, rx_ready, rx_byte   | one reader byte per request
//   res     | res_valid, res_ready, outcome | one frame result per request
//
// One byte per cycle sustained while no result is stalled; a byte is held in
// the input register and, if it ends a frame, its result is loaded into the
// result register as it leaves. Throughput is set by the single match stage:
// one position update and one byte store or compare per cycle when not stalled.
// Synchronous active-high reset clears position, mode (learn) and valids;
// the code store is left as is and is written before it is ever compared.
// A held result blocks the match stage only while res_ready stays low.
`timescale 1ns / 1ps

module tag_code_learn_and_match (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] outcome
);
  import tclm_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       step;
  match_res_t res;

  // Advance the held byte whenever the result register can take a result.
  // Simple and conservative: no byte moves while a result is stuck.
  assign step = held_valid && (!res_valid || res_ready);

  // Input stage with control-character mapping.
  tclm_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Position counter, learn/compare logic.
  tclm_match u_match (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (held_byte),
    .res  (res)
  );

  // Result register; loads only on the last byte of a frame.
  tclm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .outcome   (outcome)
  );

endmodule

FILE: design/tclm_checker.sv
// Port-level checker for the tag code block, bound to the top level.
// Depends on tclm_pkg and tag_code_learn_and_match_defines.svh.
`timescale 1ns / 1ps
`include "tag_code_learn_and_match_defines.svh"

module tclm_props (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] outcome
);
  import tclm_pkg::*;

  logic [POS_W-1:0] pos;
  logic [1:0]       pending;
  logic             seen_result;
  logic             frame_in;
  logic             res_take;

  assign frame_in = rx_valid && rx_ready && (pos == POS_W'(FRAME_LEN - 1));
  assign res_take = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      pending     <= '0;
      seen_result <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) begin
        pos <= frame_in ? '0 : pos + POS_W'(1);
      end
      pending <= pending + {1'b0, frame_in} - {1'b0, res_take};
      if (res_take) begin
        seen_result <= 1'b1;
      end
    end
  end

  `TCLM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(outcome), "result dropped or changed while stalled")
  `TCLM_ASSERT_NOW(a_res_has_frame, res_valid, pending != 2'd0,
    "result shown without a completed frame")
  `TCLM_ASSERT_NOW(a_pending_bound, 1'b1, pending != 2'd3,
    "more completed frames in flight than stages")
  `TCLM_ASSERT_NOW(a_learn_first, res_valid,
    (!seen_result && outcome == OUT_LEARNED) ||
    (seen_result && (outcome == OUT_OPEN || outcome == OUT_LOCKED)),
    "learned result must be exactly the first")

endmodule

bind tag_code_learn_and_match tclm_props u_tclm_props (
  .clk       (clk),
  .rst       (rst),
  .rx_valid  (rx_valid),
  .rx_ready  (rx_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .outcome   (outcome)
);
